### rtl/indexed_framebuffer_fill_palette_macros.svh
// Assertion macros used by the top level of the indexed framebuffer RTL.
`ifndef INDEXED_FRAMEBUFFER_FILL_PALETTE_MACROS_SVH
`define INDEXED_FRAMEBUFFER_FILL_PALETTE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define IFB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ifb assertion failed");
// Next-cycle implication, disabled during reset.
`define IFB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ifb assertion failed");
`else
`define IFB_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define IFB_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/ifb_pkg.sv
// Types, constants and helpers of the indexed framebuffer block.
package ifb_pkg;

  localparam int unsigned SCREEN_W        = 320;
  localparam int unsigned SCREEN_H        = 200;
  localparam int unsigned PALETTE_ENTRIES = 256;

  localparam int unsigned PIX_COUNT = SCREEN_W * SCREEN_H;
  localparam int unsigned PIX_AW    = $clog2(PIX_COUNT);
  localparam int unsigned COL_W     = $clog2(SCREEN_W + 1);
  localparam int unsigned ROW_W     = $clog2(SCREEN_H + 1);
  localparam int unsigned PAL_AW    = $clog2(PALETTE_ENTRIES);

  localparam logic [7:0]  COMP_MASK    = 8'd63;
  localparam logic [31:0] ALPHA_OPAQUE = 32'hff000000;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Request codes on the input word
  typedef enum logic [2:0] {
    REQ_CLEAR   = 3'd0,
    REQ_PLOT    = 3'd1,
    REQ_BAR     = 3'd2,
    REQ_PALETTE = 3'd3,
    REQ_SCAN    = 3'd4
  } req_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // Work the back end carries out
  typedef enum logic [1:0] {
    OP_FILL,
    OP_PALETTE,
    OP_SCAN,
    OP_REPORT
  } op_e;

  // Back end sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_SETUP,
    B_FILL,
    B_PAL,
    B_SCAN_PIX,
    B_SCAN_PAL,
    B_DONE
  } back_state_e;

  // Classified command passed from front to back
  typedef struct packed {
    op_e               op;
    status_e           status;
    logic [7:0]        color;
    logic [COL_W-1:0]  left;
    logic [COL_W-1:0]  right;
    logic [ROW_W-1:0]  top;
    logic [ROW_W-1:0]  bottom;
    logic [PAL_AW-1:0] entry;
    logic [23:0]       rgb;
    logic [PIX_AW-1:0] scan_addr;
  } cmd_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Keep six bits of a component and widen to eight by top-bit replication
  function automatic logic [7:0] widen6(logic [7:0] raw);
    logic [7:0] v;
    v = raw & COMP_MASK;
    return {v[5:0], v[5:4]};
  endfunction

endpackage

### rtl/ifb_front.sv
// Front end: accepts request words, clips and classifies them into commands.
module ifb_front (
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            req_type_i,
  input  logic signed [15:0]    pos_x_i,
  input  logic signed [15:0]    pos_y_i,
  input  logic signed [15:0]    rect_width_i,
  input  logic signed [15:0]    rect_height_i,
  input  logic [7:0]            fill_color_i,
  input  logic [7:0]            entry_index_i,
  input  logic [7:0]            red_raw_i,
  input  logic [7:0]            green_raw_i,
  input  logic [7:0]            blue_raw_i,
  input  logic [15:0]           pixel_index_i,
  input  ifb_pkg::q_stat_t      q_stat_i,
  output logic                  push_o,
  output ifb_pkg::cmd_t         cmd_o
);
  import ifb_pkg::*;

  localparam logic signed [17:0] W_S = signed'(18'(SCREEN_W));
  localparam logic signed [17:0] H_S = signed'(18'(SCREEN_H));

  logic signed [17:0] x_s, y_s, w_s, h_s;
  logic signed [17:0] left_s, right_s, top_s, bottom_s;
  logic               bar_empty, plot_on, scan_ok, entry_ok;

  // Stall while the queue has no free slot
  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  // Clip the bar at full width so edge sums never wrap
  always_comb begin
    x_s      = 18'(pos_x_i);
    y_s      = 18'(pos_y_i);
    w_s      = 18'(rect_width_i);
    h_s      = 18'(rect_height_i);
    left_s   = (x_s < 0) ? '0 : x_s;
    top_s    = (y_s < 0) ? '0 : y_s;
    right_s  = x_s + w_s;
    bottom_s = y_s + h_s;
    if (right_s > W_S) begin
      right_s = W_S;
    end
    if (bottom_s > H_S) begin
      bottom_s = H_S;
    end
    bar_empty = (right_s <= left_s) || (bottom_s <= top_s);
    plot_on   = (x_s >= 0) && (x_s < W_S) && (y_s >= 0) && (y_s < H_S);
    scan_ok   = 32'(pixel_index_i) < 32'(PIX_COUNT);
    entry_ok  = 32'(entry_index_i) < 32'(PALETTE_ENTRIES);
  end

  // Classify the request into one back end command
  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = OP_REPORT;
    cmd_o.status    = ST_DONE;
    cmd_o.color     = fill_color_i;
    cmd_o.entry     = PAL_AW'(entry_index_i);
    cmd_o.rgb       = {widen6(red_raw_i), widen6(green_raw_i), widen6(blue_raw_i)};
    cmd_o.scan_addr = PIX_AW'(pixel_index_i);
    unique case (req_type_i)
      REQ_CLEAR: begin
        cmd_o.op     = OP_FILL;
        cmd_o.left   = '0;
        cmd_o.right  = COL_W'(SCREEN_W);
        cmd_o.top    = '0;
        cmd_o.bottom = ROW_W'(SCREEN_H);
      end
      REQ_PLOT: begin
        if (plot_on) begin
          cmd_o.op     = OP_FILL;
          cmd_o.left   = COL_W'(x_s);
          cmd_o.right  = COL_W'(x_s) + COL_W'(1);
          cmd_o.top    = ROW_W'(y_s);
          cmd_o.bottom = ROW_W'(y_s) + ROW_W'(1);
        end else begin
          cmd_o.status = ST_EMPTY;
        end
      end
      REQ_BAR: begin
        if (!bar_empty) begin
          cmd_o.op     = OP_FILL;
          cmd_o.left   = COL_W'(left_s);
          cmd_o.right  = COL_W'(right_s);
          cmd_o.top    = ROW_W'(top_s);
          cmd_o.bottom = ROW_W'(bottom_s);
        end else begin
          cmd_o.status = ST_EMPTY;
        end
      end
      REQ_PALETTE: begin
        if (entry_ok) begin
          cmd_o.op = OP_PALETTE;
        end else begin
          cmd_o.status = ST_EMPTY;
        end
      end
      REQ_SCAN: begin
        if (scan_ok) begin
          cmd_o.op = OP_SCAN;
        end else begin
          cmd_o.status = ST_RANGE;
        end
      end
      default: begin
        cmd_o.status = ST_EMPTY;
      end
    endcase
  end

endmodule

### rtl/ifb_queue.sv
// Short command queue between the front end and the back end.
module ifb_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ifb_pkg::cmd_t    cmd_i,
  input  logic             pop_i,
  output ifb_pkg::cmd_t    cmd_o,
  output ifb_pkg::q_stat_t q_stat_o
);
  import ifb_pkg::*;

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign q_stat_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign q_stat_o.empty = (cnt_q == '0);
  assign cmd_o          = slot_q[rd_ptr_q];

  // Advance pointers with wrap and track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### rtl/ifb_back.sv
// Back end: pixel and palette memories, fill sequencer, scanout and result register.
module ifb_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ifb_pkg::cmd_t    cmd_i,
  input  ifb_pkg::q_stat_t q_stat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [31:0]      argb_pixel_o,
  output logic [1:0]       status_o
);
  import ifb_pkg::*;

  back_state_e       state_q, state_d;
  cmd_t              cmd_q;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [PIX_AW-1:0] addr_q, addr_d, base_q, base_d;
  logic              res_valid_q, res_valid_d;
  logic [31:0]       argb_q, argb_d;
  status_e           status_q, status_d;

  logic [7:0]        pix_mem [PIX_COUNT];
  logic [23:0]       pal_mem [PALETTE_ENTRIES];
  logic [7:0]        pix_rd_q;
  logic [23:0]       pal_rd_q;

  logic              last_col, last_row, out_free;
  logic              pix_we, pal_we, res_load;

  assign last_col = (col_q == cmd_q.right - COL_W'(1));
  assign last_row = (row_q == cmd_q.bottom - ROW_W'(1));
  assign out_free = !res_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (!q_stat_i.empty) begin
          unique case (cmd_i.op)
            OP_FILL:    state_d = B_SETUP;
            OP_PALETTE: state_d = B_PAL;
            OP_SCAN:    state_d = B_SCAN_PIX;
            OP_REPORT:  state_d = B_DONE;
            default:    state_d = B_DONE;
          endcase
        end
      end
      B_SETUP:    state_d = B_FILL;
      B_FILL: begin
        if (last_col && last_row) begin
          state_d = B_DONE;
        end
      end
      B_PAL:      state_d = B_DONE;
      B_SCAN_PIX: state_d = B_SCAN_PAL;
      B_SCAN_PAL: state_d = B_DONE;
      B_DONE: begin
        if (out_free) begin
          state_d = B_IDLE;
        end
      end
      default:    state_d = B_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    pop_o    = 1'b0;
    pix_we   = 1'b0;
    pal_we   = 1'b0;
    res_load = 1'b0;
    unique case (state_q)
      B_IDLE:  pop_o    = !q_stat_i.empty;
      B_FILL:  pix_we   = 1'b1;
      B_PAL:   pal_we   = 1'b1;
      B_DONE:  res_load = out_free;
      default: ;
    endcase
  end

  // Walk the fill rectangle one pixel a cycle, row by row
  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    addr_d = addr_q;
    base_d = base_q;
    if (state_q == B_SETUP) begin
      base_d = PIX_AW'(cmd_q.top) * PIX_AW'(SCREEN_W) + PIX_AW'(cmd_q.left);
      addr_d = base_d;
      row_d  = cmd_q.top;
      col_d  = cmd_q.left;
    end else if (state_q == B_FILL) begin
      if (last_col) begin
        row_d  = row_q + ROW_W'(1);
        col_d  = cmd_q.left;
        base_d = base_q + PIX_AW'(SCREEN_W);
        addr_d = base_d;
      end else begin
        col_d  = col_q + COL_W'(1);
        addr_d = addr_q + PIX_AW'(1);
      end
    end
  end

  // Build the result word
  always_comb begin
    res_valid_d = res_valid_q && out_stall_i;
    argb_d      = argb_q;
    status_d    = status_q;
    if (res_load) begin
      res_valid_d = 1'b1;
      status_d    = cmd_q.status;
      argb_d      = '0;
      if (cmd_q.op == OP_SCAN) begin
        argb_d = ALPHA_OPAQUE;
        if (32'(pix_rd_q) < 32'(PALETTE_ENTRIES)) begin
          argb_d = ALPHA_OPAQUE | {8'h00, pal_rd_q};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
    row_q    <= row_d;
    col_q    <= col_d;
    addr_q   <= addr_d;
    base_q   <= base_d;
    argb_q   <= argb_d;
    status_q <= status_d;
  end

  // Pixel memory: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (pix_we) begin
      pix_mem[addr_q] <= cmd_q.color;
    end
    pix_rd_q <= pix_mem[cmd_q.scan_addr];
  end

  // Palette memory: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[cmd_q.entry] <= cmd_q.rgb;
    end
    pal_rd_q <= pal_mem[pix_rd_q[PAL_AW-1:0]];
  end

  assign out_valid_o  = res_valid_q;
  assign argb_pixel_o = argb_q;
  assign status_o     = status_q;

endmodule

### rtl/indexed_framebuffer_fill_palette.sv
// Top level of the indexed framebuffer: front end, command queue and back end.
//
// Input channel: in_valid_i / in_stall_o carry one request word (clear, plot,
// bar fill, palette write, scanout read). Output channel: out_valid_o /
// out_stall_i carry exactly one result word per request, in request order.
// A word moves at a rising edge with valid high and stall low.
// The front end clips and classifies each word into a two-entry command
// queue; it keeps accepting while the back end works, until the queue fills.
// The back end runs one command at a time:
//   clear           whole screen, one pixel write a cycle
//   plot            single pixel write; bar fill over the clipped area
//   palette write   one entry write; scanout read: pixel then palette read
//   anything else   status result only
// The single write port of the pixel memory sets the fill rate.
// Reset clears the sequencer, queue and result valid; pixel and palette
// memories keep whatever they hold, so clear the screen and load the palette
// before scanning out. A stalled result stays in the output register; the
// back end waits with the next result until it is taken, and the queue
// keeps absorbing requests meanwhile.
`include "indexed_framebuffer_fill_palette_macros.svh"
module indexed_framebuffer_fill_palette (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         req_type_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] rect_width_i,
  input  logic signed [15:0] rect_height_i,
  input  logic [7:0]         fill_color_i,
  input  logic [7:0]         entry_index_i,
  input  logic [7:0]         red_raw_i,
  input  logic [7:0]         green_raw_i,
  input  logic [7:0]         blue_raw_i,
  input  logic [15:0]        pixel_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        argb_pixel_o,
  output logic [1:0]         status_o
);
  import ifb_pkg::*;

  cmd_t    front_cmd, head_cmd;
  q_stat_t q_stat;
  logic    q_push, q_pop;

  ifb_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .fill_color_i  (fill_color_i),
    .entry_index_i (entry_index_i),
    .red_raw_i     (red_raw_i),
    .green_raw_i   (green_raw_i),
    .blue_raw_i    (blue_raw_i),
    .pixel_index_i (pixel_index_i),
    .q_stat_i      (q_stat),
    .push_o        (q_push),
    .cmd_o         (front_cmd)
  );

  ifb_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .cmd_i    (front_cmd),
    .pop_i    (q_pop),
    .cmd_o    (head_cmd),
    .q_stat_o (q_stat)
  );

  ifb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (head_cmd),
    .q_stat_i     (q_stat),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .argb_pixel_o (argb_pixel_o),
    .status_o     (status_o)
  );

  // Only a successful scanout carries a color
  `IFB_ASSERT_IMP(a_fail_no_color, clk_i, rst_ni, out_valid_o && (status_o != ST_DONE), argb_pixel_o == '0)
  // Any nonzero color is opaque
  `IFB_ASSERT_IMP(a_color_opaque, clk_i, rst_ni, out_valid_o && (argb_pixel_o != '0), argb_pixel_o[31:24] == 8'hff)
  // An accepted word not matched by a pop leaves the queue nonempty
  `IFB_ASSERT_NXT(a_push_lands, clk_i, rst_ni, in_valid_i && !in_stall_o && !q_pop, !q_stat.empty)

endmodule

### tb/tb.sv
// Self-checking testbench for the indexed framebuffer with fill and palette requests.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ifb_pkg::*;

  localparam int unsigned STALL_LIMIT  = 200000;
  localparam int unsigned SHOW_LIMIT   = 10;
  localparam int          BIG_AREA     = 2000;
  localparam int          RANDOM_WORDS = 700;
  localparam logic [2:0]  REQ_CODE_MAX = 3'd7;

  // One request word as it appears on the input ports
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  color;
    logic [7:0]  entry;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] pix;
  } fb_word_t;

  // One result word as it appears on the output ports
  typedef struct packed {
    logic [31:0] argb;
    status_e     status;
  } fb_result_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic [2:0]         req_type_i    = '0;
  logic signed [15:0] pos_x_i       = '0;
  logic signed [15:0] pos_y_i       = '0;
  logic signed [15:0] rect_width_i  = '0;
  logic signed [15:0] rect_height_i = '0;
  logic [7:0]         fill_color_i  = '0;
  logic [7:0]         entry_index_i = '0;
  logic [7:0]         red_raw_i     = '0;
  logic [7:0]         green_raw_i   = '0;
  logic [7:0]         blue_raw_i    = '0;
  logic [15:0]        pixel_index_i = '0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic [31:0]        argb_pixel_o;
  logic [1:0]         status_o;

  // Shadow copy of screen and palette, with written flags
  logic [7:0]  shadow_pix [PIX_COUNT];
  bit          pix_known  [PIX_COUNT];
  logic [23:0] shadow_pal [PALETTE_ENTRIES];
  bit          pal_known  [PALETTE_ENTRIES];

  fb_result_t  results_due [$];
  int unsigned fault_count    = 0;
  int unsigned idle_cycles    = 0;
  int          clears_left    = 2;
  int          big_fills_left = 4;
  bit          src_calm       = 1'b0;
  bit          sink_calm      = 1'b0;
  int          sink_hold      = 0;

  indexed_framebuffer_fill_palette i_dut (.*);

  // Free-running clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Keep six bits of a component and replicate its top bits below
  function automatic logic [7:0] expand6(logic [7:0] raw);
    logic [7:0] v;
    v = raw & COMP_MASK;
    return (v << 2) | (v >> 4);
  endfunction

  // Clip a bar to the screen; edge sums are 32 bits wide so they never wrap
  function automatic bit clip_bar(fb_word_t w, output int left, output int right,
                                  output int top, output int bottom);
    int xs, ys;
    xs = $signed(w.x);
    ys = $signed(w.y);
    left   = (xs < 0) ? 0 : xs;
    top    = (ys < 0) ? 0 : ys;
    right  = xs + $signed(w.width);
    bottom = ys + $signed(w.height);
    if (right > int'(SCREEN_W)) right = SCREEN_W;
    if (bottom > int'(SCREEN_H)) bottom = SCREEN_H;
    return (right > left) && (bottom > top);
  endfunction

  // Apply one request to the shadow state and return the result it gives
  function automatic fb_result_t apply_request(fb_word_t w);
    fb_result_t res;
    int         left, right, top, bottom, xs, ys, idx, row, col;
    logic [7:0] code;
    res.argb   = '0;
    res.status = ST_DONE;
    xs = $signed(w.x);
    ys = $signed(w.y);
    case (w.kind)
      REQ_CLEAR: begin
        for (idx = 0; idx < int'(PIX_COUNT); idx++) begin
          shadow_pix[idx] = w.color;
          pix_known[idx]  = 1'b1;
        end
      end
      REQ_PLOT: begin
        if (xs >= 0 && xs < int'(SCREEN_W) && ys >= 0 && ys < int'(SCREEN_H)) begin
          idx = ys * int'(SCREEN_W) + xs;
          shadow_pix[idx] = w.color;
          pix_known[idx]  = 1'b1;
        end else begin
          res.status = ST_EMPTY;
        end
      end
      REQ_BAR: begin
        if (clip_bar(w, left, right, top, bottom)) begin
          for (row = top; row < bottom; row++) begin
            for (col = left; col < right; col++) begin
              shadow_pix[row * int'(SCREEN_W) + col] = w.color;
              pix_known[row * int'(SCREEN_W) + col]  = 1'b1;
            end
          end
        end else begin
          res.status = ST_EMPTY;
        end
      end
      REQ_PALETTE: begin
        if (w.entry < PALETTE_ENTRIES) begin
          shadow_pal[w.entry] = {expand6(w.red), expand6(w.green), expand6(w.blue)};
          pal_known[w.entry]  = 1'b1;
        end else begin
          res.status = ST_EMPTY;
        end
      end
      REQ_SCAN: begin
        if (w.pix < PIX_COUNT) begin
          code = shadow_pix[w.pix];
          res.argb = ALPHA_OPAQUE;
          if (code < PALETTE_ENTRIES) res.argb = ALPHA_OPAQUE | {8'h00, shadow_pal[code]};
        end else begin
          res.status = ST_RANGE;
        end
      end
      default: res.status = ST_EMPTY;
    endcase
    return res;
  endfunction

  // A scanout may only touch a written pixel whose palette entry is written
  function automatic bit scan_ok(int unsigned idx);
    return idx < PIX_COUNT && pix_known[idx] && pal_known[shadow_pix[idx]];
  endfunction

  // Request of the given kind with every field random
  function automatic fb_word_t word_of(logic [2:0] kind);
    fb_word_t w;
    w.kind   = kind;
    w.x      = 16'($urandom);
    w.y      = 16'($urandom);
    w.width  = 16'($urandom);
    w.height = 16'($urandom);
    w.color  = 8'($urandom);
    w.entry  = 8'($urandom);
    w.red    = 8'($urandom);
    w.green  = 8'($urandom);
    w.blue   = 8'($urandom);
    w.pix    = 16'($urandom);
    return w;
  endfunction

  function automatic fb_word_t plot_word(int x, int y, logic [7:0] color);
    fb_word_t w;
    w = word_of(REQ_PLOT);
    w.x     = 16'(x);
    w.y     = 16'(y);
    w.color = color;
    return w;
  endfunction

  function automatic fb_word_t bar_word(int x, int y, int wd, int ht, logic [7:0] color);
    fb_word_t w;
    w = word_of(REQ_BAR);
    w.x      = 16'(x);
    w.y      = 16'(y);
    w.width  = 16'(wd);
    w.height = 16'(ht);
    w.color  = color;
    return w;
  endfunction

  function automatic fb_word_t pal_word(logic [7:0] entry, logic [7:0] red,
                                        logic [7:0] green, logic [7:0] blue);
    fb_word_t w;
    w = word_of(REQ_PALETTE);
    w.entry = entry;
    w.red   = red;
    w.green = green;
    w.blue  = blue;
    return w;
  endfunction

  function automatic fb_word_t scan_word(logic [15:0] pix);
    fb_word_t w;
    w = word_of(REQ_SCAN);
    w.pix = pix;
    return w;
  endfunction

  // Prefer colors whose palette entry is already loaded
  function automatic logic [7:0] pick_color();
    logic [7:0] c;
    int         tries;
    c = 8'($urandom);
    if ($urandom_range(0, 9) < 7) begin
      for (tries = 0; tries < 16 && !pal_known[c]; tries++) c = 8'($urandom);
    end
    return c;
  endfunction

  // Find a readable pixel, or fall back to an index beyond the screen
  function automatic logic [15:0] pick_scan_index();
    int unsigned idx;
    int          tries;
    for (tries = 0; tries < 16; tries++) begin
      idx = $urandom_range(0, PIX_COUNT - 1);
      if (scan_ok(idx)) return 16'(idx);
    end
    return 16'($urandom_range(PIX_COUNT, 16'hFFFF));
  endfunction

  // Draw one random request, keeping full-screen work within budget
  function automatic fb_word_t random_request();
    fb_word_t w;
    int       sel, l, r, t, b;
    sel = $urandom_range(0, 99);
    if (sel < 2 && clears_left > 0) begin
      clears_left--;
      w = word_of(REQ_CLEAR);
      w.color = pick_color();
    end else if (sel < 28) begin
      w = word_of(REQ_PLOT);
      if ($urandom_range(0, 4) != 0) begin
        w.x = 16'(int'($urandom_range(0, SCREEN_W + 3)) - 2);
        w.y = 16'(int'($urandom_range(0, SCREEN_H + 3)) - 2);
      end
      w.color = pick_color();
    end else if (sel < 48) begin
      w = word_of(REQ_BAR);
      if ($urandom_range(0, 3) != 0) begin
        w.x      = 16'(int'($urandom_range(0, SCREEN_W + 40)) - 20);
        w.y      = 16'(int'($urandom_range(0, SCREEN_H + 40)) - 20);
        w.width  = 16'(int'($urandom_range(0, 40)) - 4);
        w.height = 16'(int'($urandom_range(0, 40)) - 4);
      end
      w.color = pick_color();
      // shrink a large bar once the budget for them is spent
      while (clip_bar(w, l, r, t, b) && (r - l) * (b - t) > BIG_AREA && big_fills_left == 0) begin
        w.width  = 16'(int'($urandom_range(0, 40)) - 4);
        w.height = 16'(int'($urandom_range(0, 40)) - 4);
      end
      if (clip_bar(w, l, r, t, b) && (r - l) * (b - t) > BIG_AREA) big_fills_left--;
    end else if (sel < 63) begin
      w = word_of(REQ_PALETTE);
    end else if (sel < 95) begin
      w = word_of(REQ_SCAN);
      if ($urandom_range(0, 5) != 0) w.pix = pick_scan_index();
      else if (w.pix < PIX_COUNT && !scan_ok(w.pix))
        w.pix = 16'($urandom_range(PIX_COUNT, 16'hFFFF));
    end else begin
      w = word_of(3'($urandom_range(REQ_SCAN + 1, REQ_CODE_MAX)));
    end
    return w;
  endfunction

  // Drive one word, hold it until accepted, then queue its expected result
  task automatic push_word(fb_word_t w);
    int gap;
    if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
    gap = src_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= w.kind;
    pos_x_i       <= w.x;
    pos_y_i       <= w.y;
    rect_width_i  <= w.width;
    rect_height_i <= w.height;
    fill_color_i  <= w.color;
    entry_index_i <= w.entry;
    red_raw_i     <= w.red;
    green_raw_i   <= w.green;
    blue_raw_i    <= w.blue;
    pixel_index_i <= w.pix;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    results_due.push_back(apply_request(w));
  endtask

  task automatic log_fault(string msg);
    if (fault_count < SHOW_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
    fault_count++;
  endtask

  // Edge cases of every request kind
  task automatic test_directed();
    int k;
    fb_word_t w;
    push_word(scan_word(16'hFFFF));
    push_word(scan_word(16'(PIX_COUNT)));
    for (k = int'(REQ_SCAN) + 1; k <= int'(REQ_CODE_MAX); k++) push_word(word_of(3'(k)));
    w = word_of(REQ_CLEAR);
    w.color = 8'h00;
    push_word(w);
    push_word(pal_word(8'h00, 8'hff, 8'hff, 8'hff));
    push_word(pal_word(8'hff, 8'hc0, 8'h3f, 8'h15));
    push_word(pal_word(8'h01, 8'h20, 8'h01, 8'hea));
    push_word(scan_word(16'h0000));
    push_word(plot_word(0, 0, 8'hff));
    push_word(plot_word(int'(SCREEN_W) - 1, int'(SCREEN_H) - 1, 8'h01));
    // off-screen plots on each edge and the field extremes
    push_word(plot_word(-1, 0, 8'h01));
    push_word(plot_word(int'(SCREEN_W), -1, 8'h01));
    push_word(plot_word(0, int'(SCREEN_H), 8'h01));
    push_word(plot_word(-32768, 32767, 8'h01));
    push_word(scan_word(16'h0000));
    push_word(scan_word(16'(PIX_COUNT - 1)));
    // empty bars, including edge sums that would wrap at 16 bits
    push_word(bar_word(10, 10, 0, 5, 8'h01));
    push_word(bar_word(10, 10, 5, -32768, 8'h01));
    push_word(bar_word(-32768, 0, 32767, 10, 8'h01));
    push_word(bar_word(32767, 32767, 32767, 32767, 8'h01));
    // bar clipped to the full screen, then a corner bar
    push_word(bar_word(-100, -100, 32767, 32767, 8'h01));
    push_word(bar_word(-5, -5, 10, 10, 8'hff));
    push_word(scan_word(16'h0000));
    push_word(scan_word(16'h0005));
  endtask

  // Hold off input until every result has drained, then resume
  task automatic test_drain_pause();
    int n;
    for (n = 0; n < 12; n++) begin
      if (n == 6) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (results_due.size() > 0);
      end
      push_word(random_request());
    end
  endtask

  // Random mix with palette-load, plot, readback sequences
  task automatic test_random(int count);
    int          n;
    int unsigned spot;
    fb_word_t    w;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        w = word_of(REQ_PALETTE);
        push_word(w);
        spot = $urandom_range(0, PIX_COUNT - 1);
        push_word(plot_word(spot % SCREEN_W, spot / SCREEN_W, w.entry));
        push_word(scan_word(16'(spot)));
      end else begin
        push_word(random_request());
      end
    end
  endtask

  // Check each accepted result against the oldest expectation, then draw a stall
  always @(posedge clk_i) begin
    fb_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (results_due.size() == 0) begin
        log_fault($sformatf("unexpected word argb %h status %0d", argb_pixel_o, status_o));
      end else begin
        want = results_due.pop_front();
        if (argb_pixel_o !== want.argb || status_o !== want.status)
          log_fault($sformatf("argb exp %h got %h, status exp %0d got %0d",
                              want.argb, argb_pixel_o, want.status, status_o));
      end
      if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
      sink_hold = sink_calm ? 0 : $urandom_range(0, 4);
    end
    if (sink_hold > 0) begin
      out_stall_i <= 1'b1;
      sink_hold--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog: end the run when neither side moves a word for too long
  always @(posedge clk_i) begin
    if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && out_stall_i === 1'b0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Reset, run the tests, drain and report
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_drain_pause();
    test_random(RANDOM_WORDS);
    in_valid_i <= 1'b0;
    while (results_due.size() > 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (fault_count == 0 && results_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
